>>> src/ascending_block_sorter_core_assert.svh
// Assertion macros shared by the sorter checker.
`ifndef ASCENDING_BLOCK_SORTER_CORE_ASSERT_SVH
`define ASCENDING_BLOCK_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorter check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define ABS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorter check failed: next-cycle rule");

`endif

>>> src/abs_pkg.sv
// Shared types and constants of the ascending block sorter.
package abs_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // One input word.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } abs_in_t;

    // One result word.
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_res;
        logic                     overflow;
    } abs_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take the input word
        logic shift;       // move the read entry one place up
        logic place;       // write the held value at the insert position
        logic emit_start;  // start reading from entry zero
        logic emit_load;   // move read data into the output register
        logic emit_next;   // advance to the next entry
        logic clear;       // start a new block
    } abs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // store holds MAX_ITEMS values
        logic shift_go;    // entry below is greater than the held value
        logic out_last;    // current entry is the final one of the block
        logic out_taken;   // output word taken this cycle
    } abs_sts_t;

endpackage

>>> src/abs_ctrl.sv
// Controller state machine of the ascending block sorter.
module abs_ctrl
    import abs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_last,
    output logic     s_ready,
    input  abs_sts_t sts,
    output abs_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT_START,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   last_pend_reg, last_pend_next;

    // Decode commands and next state
    always_comb begin
        cmd            = '0;
        s_ready        = 1'b0;
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.full) begin
                        state_next = s_last ? ST_EMIT_START : ST_IDLE;
                    end else begin
                        last_pend_next = s_last;
                        state_next     = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                if (sts.shift_go) begin
                    cmd.shift = 1'b1;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = last_pend_reg ? ST_EMIT_START : ST_IDLE;
                end
            end
            ST_EMIT_START: begin
                cmd.emit_start = 1'b1;
                state_next     = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD: begin
                cmd.emit_load = 1'b1;
                state_next    = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (sts.out_taken) begin
                    if (sts.out_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_pend_reg <= last_pend_next;
        end
    end

endmodule

>>> src/abs_dpath.sv
// Datapath of the ascending block sorter: element memory, insert pointer, output register.
module abs_dpath
    import abs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  abs_in_t  s_data,
    input  abs_cmd_t cmd,
    output abs_sts_t sts,
    output logic     m_valid,
    input  logic     m_ready,
    output abs_out_t m_data
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic signed [DATA_W-1:0] mem_r [MAX_ITEMS];

    logic [CW-1:0]            count_reg;
    logic                     ovf_reg;
    logic [AW-1:0]            pos_reg;
    logic [AW-1:0]            idx_reg;
    logic signed [DATA_W-1:0] held_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     m_valid_reg;
    abs_out_t                 m_word_reg;

    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     wr_en;
    logic [CW-1:0]            count_m1;

    assign count_m1 = count_reg - CW'(1);

    // Status toward the controller
    assign sts.full      = (count_reg == CW'(MAX_ITEMS));
    assign sts.shift_go  = (pos_reg != '0) && (rd_data_reg > held_reg);
    assign sts.out_last  = (CW'(idx_reg) == count_m1);
    assign sts.out_taken = m_valid_reg && m_ready;

    // Pick the read address for the next cycle
    always_comb begin
        priority if (cmd.load) begin
            rd_addr = count_m1[AW-1:0];
        end else if (cmd.emit_start) begin
            rd_addr = '0;
        end else if (cmd.emit_next) begin
            rd_addr = idx_reg + AW'(1);
        end else begin
            rd_addr = pos_reg - AW'(2);
        end
    end

    // Pick the write port
    assign wr_en   = cmd.shift || cmd.place;
    assign wr_addr = pos_reg;
    assign wr_data = cmd.shift ? rd_data_reg : held_reg;

    // Memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_r[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_r[rd_addr];
    end

    // Block count and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.clear) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.load) begin
            if (count_reg == CW'(MAX_ITEMS)) begin
                ovf_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Insert position, held value and emit index
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            held_reg <= s_data.value;
            pos_reg  <= count_reg[AW-1:0];
        end else if (cmd.shift) begin
            pos_reg <= pos_reg - AW'(1);
        end
        if (cmd.emit_start) begin
            idx_reg <= '0;
        end else if (cmd.emit_next) begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    // Output register: fill on load, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_word_reg.sorted_value <= rd_data_reg;
            m_word_reg.last_res     <= (CW'(idx_reg) == count_m1);
            m_word_reg.overflow     <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

endmodule

>>> src/ascending_block_sorter_core.sv
// Top level of the ascending block sorter.
// Collects a block of signed 32-bit words (the final one flagged by last) into a
// memory of MAX_ITEMS entries with one read and one write port, keeping it in
// ascending order by insertion as each word arrives, then streams the block out
// smallest first with last_res on the final word. Words beyond MAX_ITEMS are dropped
// and every result of that block carries overflow. Each input word is placed by
// the read-compare-write loop on the memory, which moves one entry per cycle past
// every already stored word greater than it; a word dropped on a full store skips the
// insert loop. Output passes the EMIT_START and EMIT_LOAD states, with the registered
// memory read feeding the output register, and waits in EMIT_WAIT until each word is
// taken before reading the next. s_ready is low while inserting or emitting.
module ascending_block_sorter_core
    import abs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  abs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output abs_out_t m_data
);

    abs_cmd_t cmd;
    abs_sts_t sts;

    abs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    abs_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> src/abs_checker.sv
// Port-level checker of the ascending block sorter and its bind.
`include "ascending_block_sorter_core_assert.svh"

module abs_checker
    import abs_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input abs_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input abs_out_t m_data
);

    // A stalled result word holds
    `ABS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // No input is taken while a result word is pending
    `ABS_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready)

    // The final input word of a block starts work that blocks input
    `ABS_ASSERT_NEXT(a_last_busy, aclk, aresetn, s_valid && s_ready && s_data.last, !s_ready)

    // Emission continues after a word that is not the final one
    `ABS_ASSERT_NEXT(a_emit_cont, aclk, aresetn, m_valid && m_ready && !m_data.last_res,
                     !s_ready)

endmodule

bind ascending_block_sorter_core abs_checker u_abs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/sv/tb.sv
// Self-checking testbench for the ascending block sorter core.
`timescale 1ns / 1ps

module tb;
    import abs_pkg::*;

    localparam int CAPACITY     = MAX_ITEMS_DEF;
    localparam int RANDOM_WORDS = 186;
    localparam int HOLD_CYCLES  = 500;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 2 * CAPACITY + 40;
    localparam int N_DIRECTED   = 24;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam abs_out_t NO_WANT = '0;

    // One directed word, with the result typed in for one-word blocks.
    typedef struct packed {
        abs_in_t  word;
        logic     typed;
        abs_out_t want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // one-word blocks at the extremes and around zero
        '{word: '{value: VAL_MAX, last: 1'b1}, typed: 1'b1,
          want: '{sorted_value: VAL_MAX, last_res: 1'b1, overflow: 1'b0}},
        '{word: '{value: VAL_MIN, last: 1'b1}, typed: 1'b1,
          want: '{sorted_value: VAL_MIN, last_res: 1'b1, overflow: 1'b0}},
        '{word: '{value: 32'sd0, last: 1'b1}, typed: 1'b1,
          want: '{sorted_value: 32'sd0, last_res: 1'b1, overflow: 1'b0}},
        '{word: '{value: -32'sd1, last: 1'b1}, typed: 1'b1,
          want: '{sorted_value: -32'sd1, last_res: 1'b1, overflow: 1'b0}},
        // descending block
        '{word: '{value: 32'sd100, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: 32'sd50, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: -32'sd50, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: VAL_MIN, last: 1'b1}, typed: 1'b0, want: NO_WANT},
        // already ascending block across the sign boundary
        '{word: '{value: VAL_MIN, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: -32'sd1, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: 32'sd0, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: VAL_MAX, last: 1'b1}, typed: 1'b0, want: NO_WANT},
        // duplicates
        '{word: '{value: 32'sd7, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: 32'sd7, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: -32'sd7, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: 32'sd7, last: 1'b1}, typed: 1'b0, want: NO_WANT},
        // alternating bit patterns
        '{word: '{value: 32'sh5555_5555, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: 32'shAAAA_AAAA, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: 32'sd1, last: 1'b1}, typed: 1'b0, want: NO_WANT},
        // repeated extremes
        '{word: '{value: VAL_MAX, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: VAL_MAX, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: VAL_MIN, last: 1'b1}, typed: 1'b0, want: NO_WANT},
        // equal pair
        '{word: '{value: 32'sd3, last: 1'b0}, typed: 1'b0, want: NO_WANT},
        '{word: '{value: 32'sd3, last: 1'b1}, typed: 1'b0, want: NO_WANT}
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    abs_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    abs_out_t m_data;

    // Sorting state kept by the testbench.
    logic signed [DATA_W-1:0] pending_block [$];
    logic                     block_overflowed;
    abs_out_t                 block_sorted_q [$];
    abs_out_t                 sorted_words_q [$];
    abs_out_t                 oldest_word;

    int  fail_cnt;
    int  results_seen;
    int  idle_cycles;
    bit  burst_mode;
    bit  long_hold_done;

    ascending_block_sorter_core #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mix extremes, a small dup-heavy range and full-range words.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return VAL_MAX;
        if (r == 1) return VAL_MIN;
        if (r < 5) return $signed($urandom_range(0, 15)) - 8;
        return $urandom;
    endfunction

    // Keep the block in ascending order; on the flagged word, list its results.
    task automatic absorb_word(input abs_in_t w);
        int pos;
        block_sorted_q.delete();
        if (pending_block.size() < CAPACITY) begin
            pos = pending_block.size();
            while (pos > 0 && pending_block[pos-1] > w.value) pos--;
            pending_block.insert(pos, w.value);
        end else begin
            block_overflowed = 1'b1;
        end
        if (w.last) begin
            foreach (pending_block[k]) begin
                block_sorted_q.push_back('{sorted_value: pending_block[k],
                                           last_res: (k == pending_block.size() - 1),
                                           overflow: block_overflowed});
            end
            pending_block.delete();
            block_overflowed = 1'b0;
        end
    endtask

    // Offer one word after an optional gap and wait until it is taken.
    task automatic offer_word(input abs_in_t w);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Send one word and queue what the predictor expects from it.
    task automatic push_word(input abs_in_t w);
        offer_word(w);
        absorb_word(w);
        foreach (block_sorted_q[k]) sorted_words_q.push_back(block_sorted_q[k]);
    endtask

    // Stimulus
    initial begin
        abs_in_t w;
        int      len;
        int      blocks;
        int      random_words;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        block_overflowed = 1'b0;
        burst_mode       = 1'b0;
        fail_cnt         = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            burst_mode = (i >= 16);
            if (DIRECTED[i].typed) begin
                offer_word(DIRECTED[i].word);
                absorb_word(DIRECTED[i].word);
                sorted_words_q.push_back(DIRECTED[i].want);
            end else begin
                push_word(DIRECTED[i].word);
            end
        end

        // random blocks: mostly short, one exactly full, one overrunning the store
        blocks       = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            if (blocks == 2) len = CAPACITY;
            else if (blocks == 6) len = CAPACITY + 3;
            else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 20);
            else len = $urandom_range(1, 8);
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                w.value = pick_value();
                w.last  = (k == len - 1);
                push_word(w);
                random_words++;
            end
            blocks++;
        end
        s_valid <= 1'b0;

        // drain, then watch for stray words
        while (sorted_words_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("ascending_block_sorter_core test passed");
        end else begin
            $display("ascending_block_sorter_core test failed");
        end
        $finish;
    end

    // Receiver: random ready pattern with one long hold-off
    initial begin
        int run;
        int gap;
        m_ready        = 1'b0;
        long_hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= 40) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 6);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Compare each result word with the oldest expectation
    initial results_seen = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (sorted_words_q.size() == 0) begin
                $error("unexpected result word: value %0d last %0b overflow %0b",
                       m_data.sorted_value, m_data.last_res, m_data.overflow);
                fail_cnt++;
            end else begin
                oldest_word = sorted_words_q.pop_front();
                if (m_data.sorted_value !== oldest_word.sorted_value) begin
                    $error("sorted_value mismatch: expected %0d, got %0d",
                           oldest_word.sorted_value, m_data.sorted_value);
                    fail_cnt++;
                end
                if (m_data.last_res !== oldest_word.last_res) begin
                    $error("last_res mismatch: expected %0b, got %0b",
                           oldest_word.last_res, m_data.last_res);
                    fail_cnt++;
                end
                if (m_data.overflow !== oldest_word.overflow) begin
                    $error("overflow mismatch: expected %0b, got %0b",
                           oldest_word.overflow, m_data.overflow);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: stop when no word moves on either side for too long
    initial idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ascending_block_sorter_core test failed");
                $finish;
            end
        end
    end

endmodule
